// ===== sv/lspr_pkg.sv =====
package lspr_pkg;

    localparam int unsigned MEMORY_FRAMES = 2097152;
    localparam int unsigned FRAC_BITS     = 16;

    localparam int unsigned ADDR_W     = $clog2(MEMORY_FRAMES);
    localparam int unsigned CNT_W      = 22;
    localparam int unsigned POS_W      = CNT_W + FRAC_BITS;
    localparam int unsigned STEP_W     = 19;
    localparam int unsigned GAIN_W     = 16;
    localparam int unsigned GAIN_SHIFT = GAIN_W - 1;
    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned LOOP_W     = 16;
    localparam int unsigned DONE_W     = 32;
    localparam int unsigned ACT_W      = 3;
    localparam int unsigned IDX_W      = 21;
    localparam int unsigned WORD_W     = 2 * SAMPLE_W;
    localparam int unsigned CFG_IDX_W  = 4;
    localparam int unsigned CFG_DATA_W = 22;

    localparam int unsigned STEP_RESET = 60211;
    localparam int unsigned GAIN_ONE   = 32768;
    localparam int          SAMPLE_MAX = 32767;
    localparam int          SAMPLE_MIN = -32768;

    localparam logic [ACT_W-1:0] ACT_WRITE   = 3'd0;
    localparam logic [ACT_W-1:0] ACT_PLAY    = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STOP    = 3'd2;
    localparam logic [ACT_W-1:0] ACT_SUSPEND = 3'd3;
    localparam logic [ACT_W-1:0] ACT_RESUME  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP        = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE      = 4'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRAP,
        S_INDEX,
        S_READ1,
        S_MUL,
        S_SUM,
        S_SCALE,
        S_EMIT
    } t_state;

endpackage

// ===== sv/lspr_if.sv =====
interface lspr_in_if;
    import lspr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ACT_W-1:0]           action;
    logic [IDX_W-1:0]           frame_index;
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic signed [LOOP_W-1:0]   loop_count;

    modport source (
        output valid, action, frame_index, left_in, right_in, loop_count,
        input  ready
    );
    modport sink (
        input  valid, action, frame_index, left_in, right_in, loop_count,
        output ready
    );
endinterface

interface lspr_out_if;
    import lspr_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       frame_valid;
    logic                       is_playing;
    logic [DONE_W-1:0]          loops_completed;

    modport source (
        output valid, left_out, right_out, frame_valid, is_playing, loops_completed,
        input  ready
    );
    modport sink (
        input  valid, left_out, right_out, frame_valid, is_playing, loops_completed,
        output ready
    );
endinterface

interface lspr_cfg_if;
    import lspr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

// ===== sv/looping_sample_player_resampler.sv =====
// Looping stereo sample player with linear-interpolation resampling.
// Channels: i_cfg writes the four registers (frame count, step, gain, enable)
// and is always ready; write it only while no item is in flight. i_in carries
// items: write frame, play, stop, suspend, resume and tick. Only a tick yields
// a result on o_out; the others update the frame memory or the transport.
// Write, play, stop, suspend and resume are done in the idle state in which
// they are accepted, and the block stays ready. A tick that plays goes
// through S_WRAP, S_INDEX and S_READ1, where two frame reads go through the
// single read port of the frame memory, then through three multiply and
// scale stages (S_MUL, S_SUM, S_SCALE) to S_EMIT, which loads the result
// register. A tick that produces no frame goes from S_WRAP to S_EMIT.
// Only one item is worked on at a time; i_in.ready is high while idle.
// A result waits in the output register while o_out.ready is low; the block
// still takes non-tick items meanwhile, and a tick waits at the end of its
// work until the output register is free.
// Reset clears the transport, loop counters and registers to their defaults;
// the frame memory is not cleared and must be written before it is played.
module looping_sample_player_resampler (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lspr_cfg_if.sink     i_cfg,
    lspr_in_if.sink      i_in,
    lspr_out_if.source   o_out
);
    import lspr_pkg::*;

    t_state                     r_state, n_state;
    logic [POS_W-1:0]           r_pos, n_pos;
    logic signed [LOOP_W-1:0]   r_rem, n_rem;
    logic [DONE_W-1:0]          r_done, n_done;
    logic                       r_playing, n_playing;
    logic                       r_suspended, n_suspended;
    logic [ADDR_W-1:0]          r_i0, n_i0;
    logic [FRAC_BITS-1:0]       r_frac, n_frac;
    logic [WORD_W-1:0]          r_w0, n_w0;
    logic                       r_frame_valid, n_frame_valid;

    logic [CNT_W-1:0]           r_frame_count;
    logic [STEP_W-1:0]          r_step;
    logic [GAIN_W-1:0]          r_gain;
    logic                       r_enabled;

    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_out_left;
    logic signed [SAMPLE_W-1:0] r_out_right;
    logic                       r_out_frame_valid;
    logic                       r_out_playing;
    logic [DONE_W-1:0]          r_out_loops;

    logic                       in_acc;
    logic                       out_load;
    logic [CNT_W-1:0]           frames_eff;
    logic [CNT_W-1:0]           last_idx;
    logic [POS_W-1:0]           track_end;
    logic                       active;
    logic [CNT_W-1:0]           pos_int;
    logic                       past_clip;
    logic [ADDR_W-1:0]          i0_sel;
    logic [FRAC_BITS-1:0]       frac_sel;
    logic [CNT_W-1:0]           i1_sum;
    logic [ADDR_W-1:0]          i1_sel;
    logic [GAIN_W-1:0]          gain_eff;

    logic                       ram_we;
    logic                       ram_re;
    logic [ADDR_W-1:0]          ram_raddr;
    logic [WORD_W-1:0]          ram_rdata;

    logic signed [SAMPLE_W-1:0] chan_left;
    logic signed [SAMPLE_W-1:0] chan_right;

    assign i_in.ready  = (r_state == S_IDLE);
    assign in_acc      = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    assign frames_eff = (r_frame_count > CNT_W'(MEMORY_FRAMES)) ? CNT_W'(MEMORY_FRAMES)
                                                                 : r_frame_count;
    assign last_idx   = frames_eff - CNT_W'(1);
    assign track_end  = {frames_eff, FRAC_BITS'(0)};
    assign active     = r_playing && !r_suspended && r_enabled && (r_frame_count != '0);
    assign pos_int    = r_pos[POS_W-1:FRAC_BITS];
    assign past_clip  = (pos_int >= frames_eff);
    assign i0_sel     = past_clip ? last_idx[ADDR_W-1:0] : pos_int[ADDR_W-1:0];
    assign frac_sel   = past_clip ? '0 : r_pos[FRAC_BITS-1:0];
    assign i1_sum     = CNT_W'(r_i0) + CNT_W'(1);
    assign i1_sel     = (i1_sum >= frames_eff) ? ((r_rem != '0) ? '0 : r_i0)
                                               : i1_sum[ADDR_W-1:0];
    assign gain_eff   = (r_gain > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : r_gain;

    assign out_load   = (r_state == S_EMIT) && (!r_out_valid || o_out.ready);

    lspr_frame_ram #(
        .DEPTH (MEMORY_FRAMES),
        .WIDTH (WORD_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in.frame_index[ADDR_W-1:0]),
        .i_wdata ({i_in.right_in, i_in.left_in}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lspr_chan u_chan_left (
        .i_clk    (i_clk),
        .i_a      (signed'(r_w0[SAMPLE_W-1:0])),
        .i_b      (signed'(ram_rdata[SAMPLE_W-1:0])),
        .i_frac   (r_frac),
        .i_gain   (gain_eff),
        .o_sample (chan_left)
    );

    lspr_chan u_chan_right (
        .i_clk    (i_clk),
        .i_a      (signed'(r_w0[WORD_W-1:SAMPLE_W])),
        .i_b      (signed'(ram_rdata[WORD_W-1:SAMPLE_W])),
        .i_frac   (r_frac),
        .i_gain   (gain_eff),
        .o_sample (chan_right)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_count <= '0;
            r_step        <= STEP_W'(STEP_RESET);
            r_gain        <= GAIN_W'(GAIN_ONE);
            r_enabled     <= 1'b1;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_FRAME_COUNT: r_frame_count <= i_cfg.data[CNT_W-1:0];
                CFG_STEP:        r_step        <= i_cfg.data[STEP_W-1:0];
                CFG_GAIN:        r_gain        <= i_cfg.data[GAIN_W-1:0];
                CFG_ENABLE:      r_enabled     <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_rem       <= '0;
            r_done      <= '0;
            r_playing   <= 1'b0;
            r_suspended <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_rem       <= n_rem;
            r_done      <= n_done;
            r_playing   <= n_playing;
            r_suspended <= n_suspended;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i0          <= n_i0;
        r_frac        <= n_frac;
        r_w0          <= n_w0;
        r_frame_valid <= n_frame_valid;
    end

    always_comb begin
        n_state       = r_state;
        n_pos         = r_pos;
        n_rem         = r_rem;
        n_done        = r_done;
        n_playing     = r_playing;
        n_suspended   = r_suspended;
        n_i0          = r_i0;
        n_frac        = r_frac;
        n_w0          = r_w0;
        n_frame_valid = r_frame_valid;
        ram_we        = 1'b0;
        ram_re        = 1'b0;
        ram_raddr     = i0_sel;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.action)
                        ACT_WRITE: begin
                            ram_we = (32'(i_in.frame_index) < MEMORY_FRAMES);
                        end
                        ACT_PLAY: begin
                            if (r_frame_count != '0) begin
                                n_pos       = '0;
                                n_rem       = i_in.loop_count;
                                n_done      = '0;
                                n_playing   = 1'b1;
                                n_suspended = 1'b0;
                            end
                        end
                        ACT_STOP: begin
                            n_playing = 1'b0;
                            n_pos     = '0;
                        end
                        ACT_SUSPEND: n_suspended = 1'b1;
                        ACT_RESUME:  n_suspended = 1'b0;
                        ACT_TICK:    n_state     = S_WRAP;
                        default: ;
                    endcase
                end
            end
            S_WRAP: begin
                if (!active) begin
                    n_frame_valid = 1'b0;
                    n_state       = S_EMIT;
                end else if (r_pos >= track_end) begin
                    if (r_rem[LOOP_W-1]) begin
                        n_pos   = r_pos - track_end;
                        n_done  = r_done + DONE_W'(1);
                        n_state = S_INDEX;
                    end else if (r_rem != '0) begin
                        n_rem   = r_rem - LOOP_W'(1);
                        n_pos   = r_pos - track_end;
                        n_done  = r_done + DONE_W'(1);
                        n_state = S_INDEX;
                    end else begin
                        // track over, no loops left
                        n_playing     = 1'b0;
                        n_frame_valid = 1'b0;
                        n_state       = S_EMIT;
                    end
                end else begin
                    n_state = S_INDEX;
                end
            end
            S_INDEX: begin
                ram_re    = 1'b1;
                ram_raddr = i0_sel;
                n_i0      = i0_sel;
                n_frac    = frac_sel;
                n_state   = S_READ1;
            end
            S_READ1: begin
                ram_re        = 1'b1;
                ram_raddr     = i1_sel;
                n_w0          = ram_rdata;
                n_pos         = r_pos + POS_W'(r_step);
                n_frame_valid = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL:   n_state = S_SUM;
            S_SUM:   n_state = S_SCALE;
            S_SCALE: n_state = S_EMIT;
            S_EMIT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_left        <= r_frame_valid ? chan_left : '0;
            r_out_right       <= r_frame_valid ? chan_right : '0;
            r_out_frame_valid <= r_frame_valid;
            r_out_playing     <= r_playing && !r_suspended;
            r_out_loops       <= r_done;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.left_out        = r_out_left;
    assign o_out.right_out       = r_out_right;
    assign o_out.frame_valid     = r_out_frame_valid;
    assign o_out.is_playing      = r_out_playing;
    assign o_out.loops_completed = r_out_loops;

`ifndef SYNTH
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(ram_we && ram_re))
        else $error("frame memory read and written in the same cycle");

    a_tick_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WRAP) |-> $past(in_acc && (i_in.action == ACT_TICK)))
        else $error("tick work started without an accepted tick item");

    a_frame_playing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.frame_valid) |-> o_out.is_playing)
        else $error("frame produced while transport not playing");
`endif

endmodule

// ===== sv/lspr_frame_ram.sv =====
module lspr_frame_ram #(
    parameter int unsigned DEPTH = 2,
    parameter int unsigned WIDTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// ===== sv/lspr_chan.sv =====
module lspr_chan (
    input  logic                                 i_clk,
    input  logic signed [lspr_pkg::SAMPLE_W-1:0] i_a,
    input  logic signed [lspr_pkg::SAMPLE_W-1:0] i_b,
    input  logic [lspr_pkg::FRAC_BITS-1:0]       i_frac,
    input  logic [lspr_pkg::GAIN_W-1:0]          i_gain,
    output logic signed [lspr_pkg::SAMPLE_W-1:0] o_sample
);
    import lspr_pkg::*;

    localparam int unsigned ACC_W = SAMPLE_W + FRAC_BITS + 2;
    localparam int unsigned MUL_W = SAMPLE_W + GAIN_W;
    localparam logic signed [SAMPLE_W:0] SAT_HI = (SAMPLE_W+1)'(SAMPLE_MAX);
    localparam logic signed [SAMPLE_W:0] SAT_LO = (SAMPLE_W+1)'(SAMPLE_MIN);

    logic [FRAC_BITS:0]              one_minus;
    logic signed [FRAC_BITS+1:0]     om_s;
    logic signed [FRAC_BITS:0]       fr_s;
    logic signed [GAIN_W:0]          g_s;
    logic signed [ACC_W-1:0]         r_p0;
    logic signed [ACC_W-1:0]         r_p1;
    logic [ACC_W-1:0]                acc_u;
    logic [ACC_W-1:0]                acc_b;
    logic signed [SAMPLE_W-1:0]      r_v;
    logic signed [MUL_W-1:0]         r_m;
    logic [MUL_W-1:0]                m_b;
    logic signed [SAMPLE_W:0]        q;

    assign one_minus = (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, i_frac};
    assign om_s      = signed'({1'b0, one_minus});
    assign fr_s      = signed'({1'b0, i_frac});
    assign g_s       = signed'({1'b0, i_gain});

    // weight both ends of the span
    always_ff @(posedge i_clk) begin
        r_p0 <= ACC_W'(i_a) * ACC_W'(om_s);
        r_p1 <= ACC_W'(i_b) * ACC_W'(fr_s);
    end

    // sum and drop fraction toward zero
    assign acc_u = r_p0 + r_p1;
    assign acc_b = acc_u + (acc_u[ACC_W-1] ? ACC_W'((1 << FRAC_BITS) - 1) : '0);

    always_ff @(posedge i_clk) begin
        r_v <= signed'(acc_b[FRAC_BITS+SAMPLE_W-1:FRAC_BITS]);
    end

    always_ff @(posedge i_clk) begin
        r_m <= MUL_W'(r_v) * MUL_W'(g_s);
    end

    // scale down toward zero and saturate
    assign m_b = r_m + (r_m[MUL_W-1] ? MUL_W'((1 << GAIN_SHIFT) - 1) : '0);
    assign q   = signed'(m_b[MUL_W-1:GAIN_SHIFT]);

    always_comb begin
        if (q > SAT_HI) begin
            o_sample = SAT_HI[SAMPLE_W-1:0];
        end else if (q < SAT_LO) begin
            o_sample = SAT_LO[SAMPLE_W-1:0];
        end else begin
            o_sample = q[SAMPLE_W-1:0];
        end
    end

endmodule

// ===== tb/sv/tb_looping_sample_player_resampler.sv =====
module tb_looping_sample_player_resampler;
    import lspr_pkg::*;

    localparam logic [ACT_W-1:0] ACT_RESERVED_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RESERVED_B = 3'd7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int SETTLE_WAIT  = 12;
    localparam int IDLE_PERCENT = 13;
    localparam int MAX_PRINTS   = 50;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       frame_valid;
        logic                       is_playing;
        logic [DONE_W-1:0]          loops_completed;
    } t_player_frame;

    logic i_clk = 1'b0;
    logic i_rst_n;

    lspr_in_if  in_ch();
    lspr_out_if out_ch();
    lspr_cfg_if cfg_ch();

    looping_sample_player_resampler dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_ch),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // player model state
    logic [WORD_W-1:0]          frame_mem [logic [IDX_W-1:0]];
    logic [POS_W-1:0]           play_pos     = '0;
    logic signed [LOOP_W-1:0]   loops_to_go  = '0;
    logic [DONE_W-1:0]          loops_done   = '0;
    logic                       playing      = 1'b0;
    logic                       suspended    = 1'b0;
    logic [CNT_W-1:0]           track_frames = '0;
    logic [STEP_W-1:0]          step_inc     = STEP_RESET;
    logic [GAIN_W-1:0]          gain_q15     = GAIN_ONE;
    logic                       play_enable  = 1'b1;

    t_player_frame expected_frames[$];
    t_player_frame frame_want;

    int          mismatches    = 0;
    int          cycles        = 0;
    int unsigned filled_frames = 0;
    bit          steady_run    = 1'b0;
    int          stall_len     = 0;
    int          stall_req     = 0;
    int          stall_seen    = 0;
    int          stall_left    = 0;

    function automatic longint trunc_shift(input longint v, input int sh);
        return (v < 0) ? -((-v) >>> sh) : (v >>> sh);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] mix_channel(
        input logic signed [SAMPLE_W-1:0] a,
        input logic signed [SAMPLE_W-1:0] b,
        input longint frac,
        input longint gain
    );
        longint acc;
        longint v;
        acc = longint'(a) * ((longint'(1) << FRAC_BITS) - frac) + longint'(b) * frac;
        v = trunc_shift(acc, FRAC_BITS);
        v = trunc_shift(v * gain, GAIN_SHIFT);
        if (v > SAMPLE_MAX) v = SAMPLE_MAX;
        else if (v < SAMPLE_MIN) v = SAMPLE_MIN;
        return v[SAMPLE_W-1:0];
    endfunction

    function automatic logic [WORD_W-1:0] read_frame(input longint unsigned idx);
        logic [IDX_W-1:0] key;
        key = idx[IDX_W-1:0];
        return frame_mem.exists(key) ? frame_mem[key] : '0;
    endfunction

    task automatic apply_config(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
        case (idx)
            CFG_FRAME_COUNT: track_frames = value[CNT_W-1:0];
            CFG_STEP:        step_inc     = value[STEP_W-1:0];
            CFG_GAIN:        gain_q15     = value[GAIN_W-1:0];
            CFG_ENABLE:      play_enable  = value[0];
            default: ;
        endcase
    endtask

    task automatic predict_player(input logic [ACT_W-1:0] action,
                                  input logic [IDX_W-1:0] idx,
                                  input logic signed [SAMPLE_W-1:0] left_in,
                                  input logic signed [SAMPLE_W-1:0] right_in,
                                  input logic signed [LOOP_W-1:0] loop_count);
        longint unsigned n;
        longint unsigned span;
        longint unsigned i0;
        longint unsigned i1;
        longint unsigned frac;
        longint unsigned g;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        bit go;
        t_player_frame f;
        f = '0;
        n = (track_frames > MEMORY_FRAMES) ? MEMORY_FRAMES : track_frames;
        g = (gain_q15 > GAIN_ONE) ? GAIN_ONE : gain_q15;
        case (action)
            ACT_WRITE: frame_mem[idx] = {right_in, left_in};
            ACT_PLAY: begin
                if (track_frames != 0) begin
                    play_pos    = '0;
                    loops_to_go = loop_count;
                    loops_done  = '0;
                    playing     = 1'b1;
                    suspended   = 1'b0;
                end
            end
            ACT_STOP: begin
                playing  = 1'b0;
                play_pos = '0;
            end
            ACT_SUSPEND: suspended = 1'b1;
            ACT_RESUME:  suspended = 1'b0;
            ACT_TICK: begin
                if (playing && !suspended && play_enable && n != 0) begin
                    span = n << FRAC_BITS;
                    go = 1'b1;
                    if (play_pos >= span) begin
                        if (loops_to_go != 0) begin
                            if (loops_to_go > 0) loops_to_go = loops_to_go - 1;
                            loops_done = loops_done + 1;
                            play_pos = play_pos - span;
                        end else begin
                            playing = 1'b0;
                            go = 1'b0;
                        end
                    end
                    if (go) begin
                        i0 = play_pos >> FRAC_BITS;
                        frac = play_pos[FRAC_BITS-1:0];
                        if (i0 >= n) begin
                            i0 = n - 1;
                            frac = 0;
                        end
                        i1 = i0 + 1;
                        if (i1 >= n) i1 = (loops_to_go != 0) ? 0 : i0;
                        w0 = read_frame(i0);
                        w1 = read_frame(i1);
                        f.left_out  = mix_channel(w0[SAMPLE_W-1:0], w1[SAMPLE_W-1:0], frac, g);
                        f.right_out = mix_channel(w0[WORD_W-1:SAMPLE_W], w1[WORD_W-1:SAMPLE_W],
                                                  frac, g);
                        f.frame_valid = 1'b1;
                        play_pos = play_pos + step_inc;
                    end
                end
                f.is_playing = playing && !suspended;
                f.loops_completed = loops_done;
                expected_frames.push_back(f);
            end
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        if (mismatches < MAX_PRINTS)
            $display("cycle %0d: %s mismatch, got %0h expected %0h", cycles, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready)
            apply_config(cfg_ch.index, cfg_ch.data);
        if (i_rst_n && in_ch.valid && in_ch.ready)
            predict_player(in_ch.action, in_ch.frame_index, in_ch.left_in, in_ch.right_in,
                           in_ch.loop_count);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_frames.size() == 0) begin
                report_mismatch("unexpected frame", out_ch.left_out, 0);
            end else begin
                frame_want = expected_frames.pop_front();
                if (out_ch.left_out !== frame_want.left_out)
                    report_mismatch("left_out", out_ch.left_out, frame_want.left_out);
                if (out_ch.right_out !== frame_want.right_out)
                    report_mismatch("right_out", out_ch.right_out, frame_want.right_out);
                if (out_ch.frame_valid !== frame_want.frame_valid)
                    report_mismatch("frame_valid", out_ch.frame_valid, frame_want.frame_valid);
                if (out_ch.is_playing !== frame_want.is_playing)
                    report_mismatch("is_playing", out_ch.is_playing, frame_want.is_playing);
                if (out_ch.loops_completed !== frame_want.loops_completed)
                    report_mismatch("loops_completed", out_ch.loops_completed,
                                    frame_want.loops_completed);
            end
        end
    end

    // hold off the output for a requested stretch, else stall at random unless in a steady run
    always @(posedge i_clk) begin
        if (stall_req != stall_seen) begin
            stall_seen <= stall_req;
            stall_left <= stall_len;
            out_ch.ready <= 1'b0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= steady_run || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    task automatic send_item(input logic [ACT_W-1:0] action,
                             input logic [IDX_W-1:0] idx,
                             input logic signed [SAMPLE_W-1:0] left_in,
                             input logic signed [SAMPLE_W-1:0] right_in,
                             input logic signed [LOOP_W-1:0] loop_count);
        while (!steady_run && $urandom_range(99) < IDLE_PERCENT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid       <= 1'b1;
        in_ch.action      <= action;
        in_ch.frame_index <= idx;
        in_ch.left_in     <= left_in;
        in_ch.right_in    <= right_in;
        in_ch.loop_count  <= loop_count;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    task automatic write_frame(input logic [IDX_W-1:0] idx,
                               input logic signed [SAMPLE_W-1:0] left_in,
                               input logic signed [SAMPLE_W-1:0] right_in);
        send_item(ACT_WRITE, idx, left_in, right_in, $urandom);
    endtask

    task automatic send_ctrl(input logic [ACT_W-1:0] action,
                             input logic signed [LOOP_W-1:0] loop_count);
        send_item(action, $urandom, $urandom, $urandom, loop_count);
    endtask

    task automatic send_ticks(input int count);
        repeat (count) send_ctrl(ACT_TICK, $urandom);
    endtask

    task automatic fill_track(input int unsigned frames);
        while (filled_frames < frames) begin
            write_frame(filled_frames, $urandom, $urandom);
            filled_frames++;
        end
    endtask

    // drop valid, drain the outstanding frames, then let the block go idle
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        settle();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic signed [LOOP_W-1:0] pick_loops();
        case ($urandom_range(4))
            0: return -1;
            1: return 0;
            2: return $urandom_range(1, 3);
            3: return $urandom;
            default: return 0;
        endcase
    endfunction

    task automatic test_idle_after_reset();
        send_ticks(1);
        send_ctrl(ACT_PLAY, 0);
        send_ticks(1);
        send_ctrl(ACT_RESERVED_A, -1);
        send_ctrl(ACT_RESERVED_B, -1);
        send_ctrl(ACT_SUSPEND, 0);
        send_ctrl(ACT_RESUME, 0);
        send_ctrl(ACT_STOP, 0);
        send_ticks(1);
    endtask

    task automatic test_default_rate();
        fill_track(4);
        write_frame(0, SAMPLE_MAX, SAMPLE_MIN);
        write_frame(1, SAMPLE_MIN, SAMPLE_MAX);
        write_frame(2, 0, -1);
        write_frame(3, -1, 0);
        write_cfg(CFG_FRAME_COUNT, 4);
        send_ctrl(ACT_PLAY, 0);
        send_ticks(6);
    endtask

    task automatic test_loops_and_transport();
        write_cfg(CFG_STEP, 1 << (FRAC_BITS - 1));
        send_ctrl(ACT_PLAY, 1);
        send_ticks(18);
        write_cfg(CFG_GAIN, 16'hFFFF);
        write_cfg(CFG_STEP, (1 << FRAC_BITS) + 12345);
        send_ctrl(ACT_PLAY, -1);
        send_ticks(5);
        send_ctrl(ACT_SUSPEND, 0);
        send_ticks(1);
        send_ctrl(ACT_RESUME, 0);
        send_ticks(1);
        write_cfg(CFG_ENABLE, 0);
        send_ticks(2);
        write_cfg(CFG_ENABLE, 1);
        send_ticks(1);
        send_ctrl(ACT_STOP, 0);
        send_ticks(1);
    endtask

    task automatic test_step_past_end();
        write_cfg(CFG_FRAME_COUNT, 2);
        write_cfg(CFG_STEP, {STEP_W{1'b1}});
        write_cfg(CFG_GAIN, 0);
        send_ctrl(ACT_PLAY, 2);
        send_ticks(3);
        write_cfg(CFG_GAIN, GAIN_ONE + 1);
        send_ticks(4);
    endtask

    task automatic test_track_shortened();
        fill_track(16);
        write_cfg(CFG_FRAME_COUNT, 16);
        write_cfg(CFG_STEP, 3 * (1 << FRAC_BITS) + 7);
        send_ctrl(ACT_PLAY, -1);
        send_ticks(4);
        write_cfg(CFG_FRAME_COUNT, 2);
        send_ticks(3);
        send_ctrl(ACT_STOP, 0);
    endtask

    task automatic test_large_track();
        write_frame({IDX_W{1'b1}}, $urandom, $urandom);
        write_cfg(CFG_FRAME_COUNT, MEMORY_FRAMES);
        write_cfg(CFG_STEP, 1 << FRAC_BITS);
        write_cfg(CFG_GAIN, GAIN_ONE);
        send_ctrl(ACT_PLAY, 0);
        send_ticks(6);
        write_cfg(CFG_FRAME_COUNT, {CNT_W{1'b1}});
        write_cfg(CFG_STEP, 0);
        send_ctrl(ACT_PLAY, 3);
        send_ticks(3);
        write_cfg(CFG_STEP, 40000);
        send_ticks(5);
        send_ctrl(ACT_STOP, 0);
        write_cfg(CFG_FRAME_COUNT, 0);
        send_ctrl(ACT_PLAY, -1);
        send_ticks(2);
    endtask

    task automatic test_output_backpressure();
        fill_track(8);
        write_cfg(CFG_FRAME_COUNT, 8);
        write_cfg(CFG_STEP, 23456);
        write_cfg(CFG_GAIN, 30000);
        send_ctrl(ACT_PLAY, -1);
        stall_len = 300;
        stall_req++;
        repeat (40) begin
            if ($urandom_range(3) == 0) write_frame($urandom_range(0, 7), $urandom, $urandom);
            else send_ticks(1);
        end
    endtask

    task automatic random_item(input int unsigned frames);
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 60) send_ticks(1);
        else if (pick < 68) send_ctrl(ACT_PLAY, pick_loops());
        else if (pick < 72) send_ctrl(ACT_STOP, $urandom);
        else if (pick < 76) send_ctrl(ACT_SUSPEND, $urandom);
        else if (pick < 80) send_ctrl(ACT_RESUME, $urandom);
        else if (pick < 92) write_frame($urandom_range(0, frames - 1), $urandom, $urandom);
        else if (pick < 96) write_frame($urandom, $urandom, $urandom);
        else send_ctrl($urandom_range(0, 1) ? ACT_RESERVED_A : ACT_RESERVED_B, $urandom);
    endtask

    task automatic test_random_playback();
        int unsigned frames;
        for (int phase = 0; phase < 6; phase++) begin
            frames = ($urandom_range(4) == 0) ? 1 : $urandom_range(2, 32);
            fill_track(frames);
            write_cfg(CFG_FRAME_COUNT, frames);
            case ($urandom_range(3))
                0: write_cfg(CFG_STEP, $urandom_range(0, (1 << STEP_W) - 1));
                1: write_cfg(CFG_STEP, $urandom_range(0, 2 << FRAC_BITS));
                2: write_cfg(CFG_STEP, 1 << FRAC_BITS);
                default: write_cfg(CFG_STEP, $urandom_range(1, 4096));
            endcase
            case ($urandom_range(2))
                0: write_cfg(CFG_GAIN, $urandom_range(0, (1 << GAIN_W) - 1));
                1: write_cfg(CFG_GAIN, $urandom_range(0, GAIN_ONE));
                default: write_cfg(CFG_GAIN, GAIN_ONE);
            endcase
            write_cfg(CFG_ENABLE, $urandom_range(9) != 0);
            steady_run = (phase == 2);
            send_ctrl(ACT_PLAY, pick_loops());
            repeat (40) random_item(frames);
        end
        steady_run = 1'b0;
    endtask

    initial begin
        in_ch.valid       = 1'b0;
        in_ch.action      = ACT_TICK;
        in_ch.frame_index = '0;
        in_ch.left_in     = '0;
        in_ch.right_in    = '0;
        in_ch.loop_count  = '0;
        out_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_FRAME_COUNT;
        cfg_ch.data       = '0;
        i_rst_n           = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_after_reset();
        test_default_rate();
        test_loops_and_transport();
        test_step_past_end();
        test_track_shortened();
        test_large_track();
        test_output_backpressure();
        test_random_playback();
        settle();

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/lspr_pkg.sv
sv/lspr_if.sv
sv/lspr_frame_ram.sv
sv/lspr_chan.sv
sv/looping_sample_player_resampler.sv
tb/sv/tb_looping_sample_player_resampler.sv
